[sv/lamp_soft_start_current_guard_macros.svh]
// ---------------------------------------------------------------------------
// lamp soft-start current guard assertion macros
// clocked property checks used by the top-level rtl, reset disables them
// ---------------------------------------------------------------------------
`ifndef LAMP_SOFT_START_CURRENT_GUARD_MACROS_SVH
`define LAMP_SOFT_START_CURRENT_GUARD_MACROS_SVH

// overlapping implication on the rising clock edge
`define LSSG_ASSERT_IMP(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication on the rising clock edge
`define LSSG_ASSERT_NXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[sv/lssg_pkg.sv]
// ---------------------------------------------------------------------------
// lssg_pkg
// shared types and constants of the lamp soft-start current guard
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lssg_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_WARM_THRESHOLD  = 3'd0;
	localparam logic [2:0] CFG_WARM_COUNT      = 3'd1;
	localparam logic [2:0] CFG_OVER_THRESHOLD  = 3'd2;
	localparam logic [2:0] CFG_OVER_LIMIT      = 3'd3;
	localparam logic [2:0] CFG_UNDER_THRESHOLD = 3'd4;
	localparam logic [2:0] CFG_UNDER_LIMIT     = 3'd5;
	localparam logic [2:0] CFG_BURST_PULSES    = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int THR_W      = 10;
	localparam int CNT_W      = 8;
	localparam int BURST_W    = 4;

	// register reset values
	localparam logic [THR_W-1:0]   RST_WARM_THRESHOLD  = 10'd56;
	localparam logic [CNT_W-1:0]   RST_WARM_COUNT      = 8'd10;
	localparam logic [THR_W-1:0]   RST_OVER_THRESHOLD  = 10'd56;
	localparam logic [CNT_W-1:0]   RST_OVER_LIMIT      = 8'd5;
	localparam logic [THR_W-1:0]   RST_UNDER_THRESHOLD = 10'd1;
	localparam logic [CNT_W-1:0]   RST_UNDER_LIMIT     = 8'd5;
	localparam logic [BURST_W-1:0] RST_BURST_PULSES    = 4'd5;

	// gate modes
	localparam logic [1:0] GATE_OFF   = 2'd0;
	localparam logic [1:0] GATE_BURST = 2'd1;
	localparam logic [1:0] GATE_PULSE = 2'd2;
	localparam logic [1:0] GATE_ON    = 2'd3;

	// phase codes as reported on the result
	localparam logic [2:0] PC_START = 3'd0;
	localparam logic [2:0] PC_WARM  = 3'd1;
	localparam logic [2:0] PC_OPEN  = 3'd2;
	localparam logic [2:0] PC_WATCH = 3'd3;
	localparam logic [2:0] PC_CLOSE = 3'd4;
	localparam logic [2:0] PC_LATCH = 3'd5;

	localparam int RES_TDATA_W = 16;

	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_WARM  = 6'b000010,
		PH_OPEN  = 6'b000100,
		PH_WATCH = 6'b001000,
		PH_CLOSE = 6'b010000,
		PH_LATCH = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [THR_W-1:0]   warm_threshold;
		logic [CNT_W-1:0]   warm_count;
		logic [THR_W-1:0]   over_threshold;
		logic [CNT_W-1:0]   over_limit;
		logic [THR_W-1:0]   under_threshold;
		logic [CNT_W-1:0]   under_limit;
		logic [BURST_W-1:0] burst_pulses;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         phase;
		logic               fault_led;
		logic [BURST_W-1:0] burst_length;
		logic [1:0]         gate_mode;
	} result_t;

	// saturating run counter
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

endpackage

[sv/lssg_cfg_regs.sv]
// ---------------------------------------------------------------------------
// lssg_cfg_regs
// configuration register file, write only
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssg_cfg_regs import lssg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  addr,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warm_threshold  <= RST_WARM_THRESHOLD;
			cfg_q.warm_count      <= RST_WARM_COUNT;
			cfg_q.over_threshold  <= RST_OVER_THRESHOLD;
			cfg_q.over_limit      <= RST_OVER_LIMIT;
			cfg_q.under_threshold <= RST_UNDER_THRESHOLD;
			cfg_q.under_limit     <= RST_UNDER_LIMIT;
			cfg_q.burst_pulses    <= RST_BURST_PULSES;
		end else if (wr_en) begin
			unique case (addr)
				CFG_WARM_THRESHOLD:  cfg_q.warm_threshold  <= wdata[THR_W-1:0];
				CFG_WARM_COUNT:      cfg_q.warm_count      <= wdata[CNT_W-1:0];
				CFG_OVER_THRESHOLD:  cfg_q.over_threshold  <= wdata[THR_W-1:0];
				CFG_OVER_LIMIT:      cfg_q.over_limit      <= wdata[CNT_W-1:0];
				CFG_UNDER_THRESHOLD: cfg_q.under_threshold <= wdata[THR_W-1:0];
				CFG_UNDER_LIMIT:     cfg_q.under_limit     <= wdata[CNT_W-1:0];
				CFG_BURST_PULSES:    cfg_q.burst_pulses    <= wdata[BURST_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/lssg_seq.sv]
// ---------------------------------------------------------------------------
// lssg_seq
// phase sequencer with over/under-current run counters
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssg_seq import lssg_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] over_sample,
	input  logic [SAMPLE_BITS-1:0] under_sample,
	input  cfg_t                   cfg,
	output result_t                res
);

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] over_run_q, over_run_d;
	logic [CNT_W-1:0] under_run_q, under_run_d;
	logic [CMP_W-1:0] os_x, us_x;
	logic [CNT_W-1:0] over_inc, under_inc;

	assign os_x      = CMP_W'(over_sample);
	assign us_x      = CMP_W'(under_sample);
	assign over_inc  = bump(over_run_q);
	assign under_inc = bump(under_run_q);

	always_comb begin
		phase_d          = phase_q;
		over_run_d       = over_run_q;
		under_run_d      = under_run_q;
		res.gate_mode    = GATE_OFF;
		res.burst_length = '0;
		res.fault_led    = 1'b0;
		res.phase        = PC_START;
		unique case (phase_q)
			PH_START: begin
				res.gate_mode    = GATE_BURST;
				res.burst_length = cfg.burst_pulses;
				phase_d          = PH_WARM;
			end
			PH_WARM: begin
				res.gate_mode = GATE_PULSE;
				res.phase     = PC_WARM;
				over_run_d    = (os_x < CMP_W'(cfg.warm_threshold)) ? over_inc : '0;
				if (over_run_d >= cfg.warm_count) phase_d = PH_OPEN;
			end
			PH_OPEN: begin
				res.gate_mode = GATE_ON;
				res.phase     = PC_OPEN;
				over_run_d    = '0;
				phase_d       = PH_WATCH;
			end
			PH_WATCH: begin
				res.gate_mode = GATE_ON;
				res.phase     = PC_WATCH;
				over_run_d    = (os_x > CMP_W'(cfg.over_threshold)) ? over_inc : '0;
				under_run_d   = (us_x < CMP_W'(cfg.under_threshold)) ? under_inc : '0;
				if (over_run_d >= cfg.over_limit || under_run_d >= cfg.under_limit)
					phase_d = PH_CLOSE;
			end
			PH_CLOSE: begin
				res.fault_led = 1'b1;
				res.phase     = PC_CLOSE;
				phase_d       = PH_LATCH;
			end
			PH_LATCH: begin
				res.fault_led = 1'b1;
				res.phase     = PC_LATCH;
			end
			default: begin
				phase_d = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			over_run_q  <= '0;
			under_run_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			over_run_q  <= over_run_d;
			under_run_q <= under_run_d;
		end
	end

endmodule

[sv/lssg_out_reg.sv]
// ---------------------------------------------------------------------------
// lssg_out_reg
// result register on the master side of the stream
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssg_out_reg import lssg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    free,
	output logic    tvalid,
	input  logic    tready,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	// the slot opens when empty or when the held beat leaves this cycle
	assign free = !valid_q || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign tvalid  = valid_q;
	assign res_out = res_q;

endmodule

[sv/lamp_soft_start_current_guard.sv]
// ---------------------------------------------------------------------------
// lamp_soft_start_current_guard: beats pass the input stage and result registers
// throughput one beat per cycle if not stalled, set by the single-pass update loop
// reset: phase startup, run counters 0, registers at their defaults, no beats
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lamp_soft_start_current_guard_macros.svh"

module lamp_soft_start_current_guard import lssg_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]              cfg_addr,
	input  logic [CFG_DATA_W-1:0]             cfg_wdata,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: over_sample, under_sample, zero fill
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: gate_mode[1:0], burst_length[5:2], fault_led[6], phase[9:7], zero fill
	output logic [RES_TDATA_W-1:0]            m_tdata
);

	localparam int RES_W = $bits(result_t);

	cfg_t                   cfg;
	result_t                res_c, res_o;

	// input stage: one sample pair waits here for the sequencer
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] over_s1, under_s1;

	logic                   out_free;
	logic                   adv;

	// a beat advances whenever the result slot can take it
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// sample payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			over_s1  <= s_tdata[SAMPLE_BITS-1:0];
			under_s1 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
	end

	lssg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// phase update and result forming, state moves only when the beat advances
	lssg_seq #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.over_sample  (over_s1),
		.under_sample (under_s1),
		.cfg          (cfg),
		.res          (res_c)
	);

	lssg_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv),
		.res_in  (res_c),
		.free    (out_free),
		.tvalid  (m_tvalid),
		.tready  (m_tready),
		.res_out (res_o)
	);

	assign m_tdata = {{(RES_TDATA_W-RES_W){1'b0}}, res_o};

	// fault only shows in the closing and latched phases
	`LSSG_ASSERT_IMP(a_fault_phase, m_tvalid && res_o.fault_led,
		res_o.phase == PC_CLOSE || res_o.phase == PC_LATCH, "fault outside closing/latched")

	// a burst length only travels with a burst request
	`LSSG_ASSERT_IMP(a_burst_gate, m_tvalid && (res_o.burst_length != '0),
		res_o.gate_mode == GATE_BURST, "burst length without burst gate mode")

	// a waiting sample pair is never dropped
	`LSSG_ASSERT_NXT(a_s1_hold, valid_s1 && !adv, valid_s1, "pending sample pair lost")

endmodule
